[src/sparse_set_map_macros.svh]
// Assertion helpers used by sparse_set_map.sv.
`ifndef SPARSE_SET_MAP_MACROS_SVH
`define SPARSE_SET_MAP_MACROS_SVH

// Property that is checked only while the block is out of reset.
`define SSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that is also checked while reset is held.
`define SSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/ssm_pkg.sv]
`default_nettype none

package ssm_pkg;

  // Map geometry.
  localparam int unsigned KEY_BITS   = 10;
  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned KEY_SPACE  = 1 << KEY_BITS;
  localparam int unsigned SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned COUNT_BITS = $clog2(CAPACITY + 1);

  // Reset sweep covers the larger of the sparse and dense tables.
  localparam int unsigned CLR_DEPTH  = (KEY_SPACE > CAPACITY) ? KEY_SPACE : CAPACITY;
  localparam int unsigned CLR_BITS   = $clog2(CLR_DEPTH);

  // Stream field widths.
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned KEY_W      = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned IN_W       = 48;
  localparam int unsigned OUT_W      = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT           = 3'd0,
    CMD_ERASE            = 3'd1,
    CMD_LOOKUP           = 3'd2,
    CMD_LOOKUP_OR_INSERT = 3'd3,
    CMD_CLEAR            = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_ABSENT  = 2'd1,
    STAT_PRESENT = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_LOOK,
    S_EVAL
  } state_e;

endpackage

`default_nettype wire

[src/ssm_ram.sv]
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ssm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/sparse_set_map.sv]
// Channel   Dir  Beat fields (lowest bit up)
// s_axis    in   command[2:0], key[12:3], value_in[44:13], zero pad[47:45]
// m_axis    out  status[1:0], present[2], slot[12:3], value_out[44:13], count[55:45]
//
// Every command steps through accept, sparse-table read, dense read and write
// back. The chain of dependent reads through the two tables sets these steps.
// After reset the sparse and dense key tables are swept to zero, one entry a
// cycle, over all 1024 entries; s_axis_tready stays low until the sweep is done.
// A finished result waits in the output register while the next command is
// accepted; a command stalls in its last cycle only while that register is full.
`default_nettype none

`include "sparse_set_map_macros.svh"

module sparse_set_map (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // command[2:0], key[12:3], value_in[44:13], zero pad[47:45]
  input  wire logic [ssm_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // status[1:0], present[2], slot[12:3], value_out[44:13], count[55:45]
  output logic      [ssm_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned KB = ssm_pkg::KEY_BITS;
  localparam int unsigned SB = ssm_pkg::SLOT_BITS;
  localparam int unsigned CB = ssm_pkg::COUNT_BITS;
  localparam int unsigned DW = ssm_pkg::DATA_WIDTH;
  localparam int unsigned LB = ssm_pkg::CLR_BITS;

  ssm_pkg::state_e state_q, state_d;

  logic [LB-1:0]             clr_q;
  logic [CB-1:0]             count_q, count_d;
  logic [ssm_pkg::CMD_W-1:0] cmd_q;
  logic [KB-1:0]             key_q;
  logic [DW-1:0]             val_q;
  logic [KB-1:0]             lk_q;
  logic [DW-1:0]             lv_q;

  logic                      out_valid_q;
  logic [ssm_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic                      out_present_q, out_present_d;
  logic [SB-1:0]             out_slot_q, out_slot_d;
  logic [DW-1:0]             out_value_q, out_value_d;
  logic [CB-1:0]             out_count_q;

  logic                      in_beat, out_beat, adv;
  logic                      retire;
  logic [CB-1:0]             count_m1;
  logic [SB-1:0]             last_slot;
  logic [SB-1:0]             hit_slot;
  logic                      here, full;
  logic                      do_insert, do_erase;
  logic [DW-1:0]             new_value;

  // RAM port signals.
  logic          sp_we, sp_re, dk_we, dk_re, dv_we, dv_re;
  logic [KB-1:0] sp_waddr, sp_raddr;
  logic [SB-1:0] sp_wdata, sp_rdata;
  logic [SB-1:0] dk_waddr, dk_raddr, dv_waddr, dv_raddr;
  logic [KB-1:0] dk_wdata, dk_rdata;
  logic [DW-1:0] dv_wdata, dv_rdata;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign adv      = !out_valid_q || m_axis_tready;
  assign retire   = (state_q == ssm_pkg::S_EVAL) && adv;

  assign s_axis_tready = (state_q == ssm_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {ssm_pkg::COUNT_W'(out_count_q), ssm_pkg::VALUE_W'(out_value_q),
                          ssm_pkg::SLOT_W'(out_slot_q), out_present_q, out_status_q};

  // Presence test on the values read back for the held command.
  assign count_m1  = count_q - CB'(1);
  assign last_slot = count_m1[SB-1:0];
  assign hit_slot  = sp_rdata;
  assign here      = (CB'(hit_slot) < count_q) && (dk_rdata == key_q);
  assign full      = (count_q >= CB'(ssm_pkg::CAPACITY));
  assign new_value = (cmd_q == ssm_pkg::CMD_INSERT) ? val_q : '0;

  // Next state, memory control and result.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    do_insert     = 1'b0;
    do_erase      = 1'b0;
    out_status_d  = ssm_pkg::STAT_OK;
    out_present_d = 1'b0;
    out_slot_d    = '0;
    out_value_d   = '0;

    sp_re    = 1'b0;
    sp_raddr = s_axis_tdata[ssm_pkg::CMD_W +: KB];
    dk_re    = 1'b0;
    dk_raddr = last_slot;
    dv_re    = 1'b0;
    dv_raddr = last_slot;

    case (cmd_q)
      ssm_pkg::CMD_INSERT, ssm_pkg::CMD_LOOKUP_OR_INSERT: begin
        if (here) begin
          out_status_d  = (cmd_q == ssm_pkg::CMD_INSERT) ? ssm_pkg::STAT_PRESENT
                                                         : ssm_pkg::STAT_OK;
          out_present_d = 1'b1;
          out_slot_d    = hit_slot;
          out_value_d   = dv_rdata;
        end else if (full) begin
          out_status_d  = ssm_pkg::STAT_FULL;
        end else begin
          do_insert     = 1'b1;
          out_slot_d    = count_q[SB-1:0];
          out_value_d   = new_value;
          count_d       = count_q + CB'(1);
        end
      end
      ssm_pkg::CMD_ERASE: begin
        if (here) begin
          do_erase      = 1'b1;
          out_present_d = 1'b1;
          count_d       = count_m1;
        end else begin
          out_status_d  = ssm_pkg::STAT_ABSENT;
        end
      end
      ssm_pkg::CMD_CLEAR: begin
        out_present_d = here;
        count_d       = '0;
      end
      default: begin
        if (here) begin
          out_present_d = 1'b1;
          out_slot_d    = hit_slot;
          out_value_d   = dv_rdata;
        end else begin
          out_status_d  = ssm_pkg::STAT_ABSENT;
        end
      end
    endcase

    case (state_q)
      ssm_pkg::S_CLR: begin
        if (clr_q == LB'(ssm_pkg::CLR_DEPTH - 1)) begin
          state_d = ssm_pkg::S_IDLE;
        end
      end
      ssm_pkg::S_IDLE: begin
        // Sparse entry of the new key, and the last dense entry for erase.
        if (in_beat) begin
          sp_re   = 1'b1;
          dk_re   = 1'b1;
          dv_re   = 1'b1;
          state_d = ssm_pkg::S_LOOK;
        end
      end
      ssm_pkg::S_LOOK: begin
        // Dense key and value at the slot the sparse table points to.
        dk_re    = 1'b1;
        dk_raddr = sp_rdata;
        dv_re    = 1'b1;
        dv_raddr = sp_rdata;
        state_d  = ssm_pkg::S_EVAL;
      end
      ssm_pkg::S_EVAL: begin
        if (adv) begin
          state_d = ssm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ssm_pkg::S_IDLE;
      end
    endcase
  end

  // Write ports: zero sweep after reset, else the insert or erase update.
  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = key_q;
    sp_wdata = count_q[SB-1:0];
    dk_we    = 1'b0;
    dk_waddr = count_q[SB-1:0];
    dk_wdata = key_q;
    dv_we    = 1'b0;
    dv_waddr = count_q[SB-1:0];
    dv_wdata = new_value;
    if (state_q == ssm_pkg::S_CLR) begin
      sp_we    = ((LB + 1)'(clr_q) < (LB + 1)'(ssm_pkg::KEY_SPACE));
      sp_waddr = clr_q[KB-1:0];
      sp_wdata = '0;
      dk_we    = ((LB + 1)'(clr_q) < (LB + 1)'(ssm_pkg::CAPACITY));
      dk_waddr = clr_q[SB-1:0];
      dk_wdata = '0;
    end else if (state_q == ssm_pkg::S_EVAL && adv) begin
      if (do_insert) begin
        sp_we = 1'b1;
        dk_we = 1'b1;
        dv_we = 1'b1;
      end else if (do_erase) begin
        // Move the last entry into the freed slot and repoint its key.
        sp_we    = 1'b1;
        sp_waddr = lk_q;
        sp_wdata = hit_slot;
        dk_we    = 1'b1;
        dk_waddr = hit_slot;
        dk_wdata = lk_q;
        dv_we    = 1'b1;
        dv_waddr = hit_slot;
        dv_wdata = lv_q;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssm_pkg::S_CLR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ssm_pkg::S_CLR) begin
        clr_q <= clr_q + LB'(1);
      end
      if (state_q == ssm_pkg::S_EVAL && adv) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_beat) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      cmd_q <= s_axis_tdata[ssm_pkg::CMD_W-1:0];
      key_q <= s_axis_tdata[ssm_pkg::CMD_W +: KB];
      val_q <= DW'(s_axis_tdata[ssm_pkg::CMD_W + ssm_pkg::KEY_W +: ssm_pkg::VALUE_W]);
    end
    if (state_q == ssm_pkg::S_LOOK) begin
      lk_q <= dk_rdata;
      lv_q <= dv_rdata;
    end
    if (state_q == ssm_pkg::S_EVAL && adv) begin
      out_status_q  <= out_status_d;
      out_present_q <= out_present_d;
      out_slot_q    <= out_slot_d;
      out_value_q   <= out_value_d;
      out_count_q   <= count_d;
    end
  end

  // Sparse table: slot of each key.
  ssm_ram #(
    .WIDTH (SB),
    .DEPTH (ssm_pkg::KEY_SPACE)
  ) u_sparse (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (sp_waddr),
    .wdata_i (sp_wdata),
    .re_i    (sp_re),
    .raddr_i (sp_raddr),
    .rdata_o (sp_rdata)
  );

  // Dense keys.
  ssm_ram #(
    .WIDTH (KB),
    .DEPTH (ssm_pkg::CAPACITY)
  ) u_dense_key (
    .clk_i   (clk_i),
    .we_i    (dk_we),
    .waddr_i (dk_waddr),
    .wdata_i (dk_wdata),
    .re_i    (dk_re),
    .raddr_i (dk_raddr),
    .rdata_o (dk_rdata)
  );

  // Dense values.
  ssm_ram #(
    .WIDTH (DW),
    .DEPTH (ssm_pkg::CAPACITY)
  ) u_dense_val (
    .clk_i   (clk_i),
    .we_i    (dv_we),
    .waddr_i (dv_waddr),
    .wdata_i (dv_wdata),
    .re_i    (dv_re),
    .raddr_i (dv_raddr),
    .rdata_o (dv_rdata)
  );

  // Checks.
  `SSM_ASSERT(a_count_bound, count_q <= CB'(ssm_pkg::CAPACITY), "count above capacity")
  `SSM_ASSERT(a_accept_to_look, in_beat |=> state_q == ssm_pkg::S_LOOK, "accept without read")
  `SSM_ASSERT(a_eval_emits, retire |=> out_valid_q, "finished command gave no result")
  `SSM_ASSERT(a_erase_shrinks, (retire && do_erase) |=> count_q == $past(count_m1), "bad erase")
  `SSM_ASSERT_ALWAYS(a_no_value_write, !rst_ni |-> !dv_we, "value store written in reset")

endmodule

`default_nettype wire
